// ----- hdl/dnsrae_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS reply A-record extractor: shared types and constants
// Transfer payloads, verdict codes, parse phases and DNS wire constants.
// ----------------------------------------------------------------------------
package dnsrae_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned FIXED_Q_BYTES = 4;
    localparam int unsigned ADDR_BYTES = 4;

    localparam logic [1:0] LABEL_PLAIN = 2'b00;
    localparam logic [1:0] LABEL_PTR = 2'b11;

    localparam logic [15:0] TYPE_A = 16'h0001;
    localparam logic [15:0] A_RDLENGTH = 16'h0004;

    typedef enum logic [2:0] {
        ST_FOUND       = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_SERVER_ERR  = 3'd2,
        ST_NO_ANSWERS  = 3'd3,
        ST_BAD_NAME    = 3'd4,
        ST_TRUNCATED   = 3'd5,
        ST_NO_A_RECORD = 3'd6
    } t_status;

    typedef enum logic [10:0] {
        PH_HEADER = 11'b000_0000_0001,
        PH_QLEN   = 11'b000_0000_0010,
        PH_QLABEL = 11'b000_0000_0100,
        PH_QPTR   = 11'b000_0000_1000,
        PH_QFIXED = 11'b000_0001_0000,
        PH_ALEN   = 11'b000_0010_0000,
        PH_ALABEL = 11'b000_0100_0000,
        PH_APTR   = 11'b000_1000_0000,
        PH_AFIXED = 11'b001_0000_0000,
        PH_AADDR  = 11'b010_0000_0000,
        PH_ASKIP  = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
        logic [3:0]  response_code;
    } t_out_item;

endpackage

// ----- hdl/dns_reply_a_record_extract_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS reply A-record extractor
// Streams a DNS reply one byte per transfer on the input channel, with a mark
// on the final byte, and gives one verdict per message on the output channel:
// the first A record address with rdlength 4, or an error code.
// Both channels use valid/stall; a transfer happens on a rising edge with
// valid high and stall low. One byte is accepted every cycle while no result
// waits under i_out_stall. A verdict is registered: the byte that decides it
// is taken into the input register, and the result register, which drives
// o_out_valid, loads from the input register. Bytes after a verdict give
// nothing until the last-byte mark restarts parsing.
// Throughput: one byte per cycle while no result waits under i_out_stall,
// set by the single-pass parse step between the input and result registers.
// Stall: while a result waits under i_out_stall the input register holds its
// byte and o_in_stall rises once that register is full.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// parser to the start of a message.
// ----------------------------------------------------------------------------
module dns_reply_a_record_extract_unit
    import dnsrae_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = 512,
    parameter int unsigned MAX_LABELS = 16,
    parameter int unsigned NAME_BUFFER_CHARS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int unsigned CNT_W = $clog2(NAME_BUFFER_CHARS);
    localparam int unsigned LAB_W = $clog2(MAX_LABELS + 2);

    logic             r_in_valid;
    t_in_item         r_in_data;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic [15:0]      r_q, n_q;
    logic [15:0]      r_a, n_a;
    logic [5:0]       r_lbl_left, n_lbl_left;
    logic [CNT_W-1:0] r_chars, n_chars;
    logic [LAB_W-1:0] r_labels, n_labels;
    logic [3:0]       r_fidx, n_fidx;
    logic [15:0]      r_rtype, n_rtype;
    logic [15:0]      r_rlen, n_rlen;
    logic [31:0]      r_shift, n_shift;
    logic             r_verdict, n_verdict;
    logic [3:0]       r_rcode, n_rcode;

    logic             adv;
    logic             in_ready;
    logic             proc;
    logic             emit;
    t_out_item        n_out_data;
    logic [7:0]       v;
    logic             is_q;
    logic [CNT_W:0]   char_sum;
    logic [15:0]      plen;

    assign adv = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_ready = !r_in_valid || adv;
    assign o_in_stall = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

    assign v = r_in_data.msg_byte;
    assign is_q = (r_phase == PH_QLEN) || (r_phase == PH_QLABEL) || (r_phase == PH_QPTR);
    assign char_sum = {1'b0, r_chars} + (CNT_W + 1)'(v[5:0]) + (CNT_W + 1)'(1);
    assign plen = {r_rlen[15:8], v};

    always_comb begin
        n_pos = r_pos;
        n_phase = r_phase;
        n_q = r_q;
        n_a = r_a;
        n_lbl_left = r_lbl_left;
        n_chars = r_chars;
        n_labels = r_labels;
        n_fidx = r_fidx;
        n_rtype = r_rtype;
        n_rlen = r_rlen;
        n_shift = r_shift;
        n_rcode = r_rcode;
        emit = 1'b0;
        n_out_data.status = ST_FOUND;
        n_out_data.address = 32'h0;
        n_out_data.response_code = 4'h0;

        proc = !r_verdict && (r_pos < POS_W'(MAX_MESSAGE_BYTES));

        if (proc) begin
            n_pos = r_pos + POS_W'(1);
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(3)) begin
                        n_rcode = v[3:0];
                    end else if (r_pos == POS_W'(4)) begin
                        n_q = {v, 8'h00};
                    end else if (r_pos == POS_W'(5)) begin
                        n_q = {r_q[15:8], v};
                    end else if (r_pos == POS_W'(6)) begin
                        n_a = {v, 8'h00};
                    end else if (r_pos == POS_W'(7)) begin
                        n_a = {r_a[15:8], v};
                    end else if (r_pos == POS_W'(HEADER_BYTES - 1)) begin
                        if (r_rcode != 4'h0) begin
                            emit = 1'b1;
                            n_out_data.status = ST_SERVER_ERR;
                        end else if (r_a == 16'h0) begin
                            emit = 1'b1;
                            n_out_data.status = ST_NO_ANSWERS;
                        end else begin
                            n_phase = (r_q == 16'h0) ? PH_ALEN : PH_QLEN;
                            n_chars = '0;
                            n_labels = '0;
                            n_lbl_left = '0;
                        end
                    end
                end
                PH_QLEN, PH_ALEN: begin
                    if (v == 8'h00) begin
                        n_phase = is_q ? PH_QFIXED : PH_AFIXED;
                        n_fidx = '0;
                        n_rtype = '0;
                        n_rlen = '0;
                    end else if (v[7:6] == LABEL_PTR) begin
                        n_phase = is_q ? PH_QPTR : PH_APTR;
                    end else if (v[7:6] != LABEL_PLAIN) begin
                        emit = 1'b1;
                        n_out_data.status = ST_BAD_NAME;
                    end else if (char_sum >= (CNT_W + 1)'(NAME_BUFFER_CHARS)) begin
                        emit = 1'b1;
                        n_out_data.status = ST_BAD_NAME;
                    end else begin
                        n_chars = char_sum[CNT_W-1:0];
                        n_lbl_left = v[5:0];
                        n_phase = is_q ? PH_QLABEL : PH_ALABEL;
                    end
                end
                PH_QLABEL, PH_ALABEL: begin
                    n_lbl_left = r_lbl_left - 6'd1;
                    if (r_lbl_left == 6'd1) begin
                        n_labels = r_labels + LAB_W'(1);
                        if (r_labels == LAB_W'(MAX_LABELS)) begin
                            emit = 1'b1;
                            n_out_data.status = ST_BAD_NAME;
                        end else begin
                            n_phase = is_q ? PH_QLEN : PH_ALEN;
                        end
                    end
                end
                PH_QPTR, PH_APTR: begin
                    n_phase = is_q ? PH_QFIXED : PH_AFIXED;
                    n_fidx = '0;
                    n_rtype = '0;
                    n_rlen = '0;
                end
                PH_QFIXED: begin
                    n_fidx = r_fidx + 4'd1;
                    if (r_fidx == 4'(FIXED_Q_BYTES - 1)) begin
                        n_q = r_q - 16'd1;
                        n_phase = (r_q == 16'd1) ? PH_ALEN : PH_QLEN;
                        n_chars = '0;
                        n_labels = '0;
                        n_lbl_left = '0;
                    end
                end
                PH_AFIXED: begin
                    n_fidx = r_fidx + 4'd1;
                    if (r_fidx == 4'd0) begin
                        n_rtype = {v, 8'h00};
                    end else if (r_fidx == 4'd1) begin
                        n_rtype = {r_rtype[15:8], v};
                    end else if (r_fidx == 4'd8) begin
                        n_rlen = {v, 8'h00};
                    end else if (r_fidx == 4'd9) begin
                        n_rlen = plen;
                        if ((r_rtype == TYPE_A) && (plen == A_RDLENGTH)) begin
                            n_phase = PH_AADDR;
                            n_fidx = '0;
                            n_shift = '0;
                        end else if (r_a <= 16'd1) begin
                            emit = 1'b1;
                            n_out_data.status = ST_NO_A_RECORD;
                        end else if (plen == 16'h0) begin
                            n_a = r_a - 16'd1;
                            n_phase = PH_ALEN;
                            n_chars = '0;
                            n_labels = '0;
                            n_lbl_left = '0;
                        end else begin
                            n_phase = PH_ASKIP;
                        end
                    end
                end
                PH_AADDR: begin
                    n_shift = {r_shift[23:0], v};
                    n_fidx = r_fidx + 4'd1;
                    if (r_fidx == 4'(ADDR_BYTES - 1)) begin
                        emit = 1'b1;
                        n_out_data.status = ST_FOUND;
                        n_out_data.address = {r_shift[23:0], v};
                    end
                end
                PH_ASKIP: begin
                    n_rlen = r_rlen - 16'd1;
                    if (r_rlen == 16'd1) begin
                        n_a = r_a - 16'd1;
                        n_phase = PH_ALEN;
                        n_chars = '0;
                        n_labels = '0;
                        n_lbl_left = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        n_verdict = r_verdict || emit;

        if (r_in_data.last_byte && !n_verdict) begin
            emit = 1'b1;
            n_out_data.address = 32'h0;
            n_out_data.status = (n_pos < POS_W'(HEADER_BYTES)) ? ST_TOO_SHORT : ST_TRUNCATED;
        end
        n_out_data.response_code = n_rcode;

        if (r_in_data.last_byte) begin
            n_pos = '0;
            n_phase = PH_HEADER;
            n_q = '0;
            n_a = '0;
            n_lbl_left = '0;
            n_chars = '0;
            n_labels = '0;
            n_fidx = '0;
            n_rtype = '0;
            n_rlen = '0;
            n_shift = '0;
            n_verdict = 1'b0;
            n_rcode = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos <= '0;
            r_phase <= PH_HEADER;
            r_q <= '0;
            r_a <= '0;
            r_lbl_left <= '0;
            r_chars <= '0;
            r_labels <= '0;
            r_fidx <= '0;
            r_rtype <= '0;
            r_rlen <= '0;
            r_shift <= '0;
            r_verdict <= 1'b0;
            r_rcode <= '0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= emit;
                r_pos <= n_pos;
                r_phase <= n_phase;
                r_q <= n_q;
                r_a <= n_a;
                r_lbl_left <= n_lbl_left;
                r_chars <= n_chars;
                r_labels <= n_labels;
                r_fidx <= n_fidx;
                r_rtype <= n_rtype;
                r_rlen <= n_rlen;
                r_shift <= n_shift;
                r_verdict <= n_verdict;
                r_rcode <= n_rcode;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (adv && emit) begin
            r_out_data <= n_out_data;
        end
    end

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("parse phase not one-hot");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_FOUND) |-> o_out_data.address == 32'h0)
        else $error("address not zero on an error verdict");

    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_verdict && !r_in_data.last_byte |=> !o_out_valid)
        else $error("second verdict within one message");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_data.last_byte |=> (r_pos == '0) && (r_phase == PH_HEADER) && !r_verdict)
        else $error("parser not restarted after last byte");

    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_data.last_byte && !r_verdict |=> o_out_valid)
        else $error("message ended without a verdict");

endmodule
